// ===== hdl/bounded_deque_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_assert.svh
// assertion macros used by the bounded_deque_with_search design file
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define BDQS_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BDQS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bdqs_pkg.sv =====
// ----------------------------------------------------------------------------
// bdqs_pkg
// sizes, operation and status codes, sequencer states and ring index steps of the deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdqs_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int OP_W   = 3;
   localparam int WORD_W = 32;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   localparam int REQ_TDATA_W = ((OP_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((STAT_W + OCC_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUT_BACK   = 3'd0,
      OP_PUT_FRONT  = 3'd1,
      OP_TAKE_BACK  = 3'd2,
      OP_TAKE_FRONT = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // ring index step, capacity need not be a power of two
   function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] i);
      slot_next = (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] i);
      slot_prev = (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
   endfunction

endpackage

// ===== hdl/bdqs_ram.sv =====
// ----------------------------------------------------------------------------
// bdqs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdqs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue in a ring ram, with a front-to-back value search
// ----------------------------------------------------------------------------
//   channel  dir  tdata fields (low bit first)        transfer
//   req_     in   op[2:0], data_word[34:3], pad        tvalid & tready
//   rsp_     out  status[1:0], occupancy[6:2], pad     tvalid & tready
//
//   push, pop, clear and unused codes: result loaded at the transfer
//   search: one ram read per cycle through the single read port and one
//   shared compare; ends early on a hit
//   req_tready is high only in idle with the result register free or draining
//   reset is synchronous and empties the queue; no clearing pass of the ram
//   a stalled rsp_ holds its result and blocks the next request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bounded_deque_with_search_assert.svh"

module bounded_deque_with_search
   import bdqs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // op, data_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // status, occupancy
);

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      front_ff, front_in;
   logic [IDX_W-1:0]      back_ff, back_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DATA_WIDTH-1:0] key_ff, key_in;
   logic [IDX_W-1:0]      pos_ff, pos_in;
   logic [CNT_W-1:0]      issued_ff, issued_in;
   logic                  pend_ff, pend_in;
   logic                  found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  req_xfer;
   logic                  out_free;
   op_type                req_op;
   logic [WORD_W-1:0]     req_word;
   logic [DATA_WIDTH+WORD_W-1:0] word_ext;
   logic [DATA_WIDTH-1:0] req_key;
   logic [CNT_W+OCC_W-1:0] occ_ext;

   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic                  rd_en;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  is_full;
   logic                  is_empty;
   logic                  hit;
   status_type            status;

   assign req_op   = op_type'(req_tdata[OP_W-1:0]);
   assign req_word = req_tdata[OP_W+WORD_W-1:OP_W];
   assign word_ext = {{DATA_WIDTH{1'b0}}, req_word};
   assign req_key  = word_ext[DATA_WIDTH-1:0];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_xfer   = req_tvalid && req_tready;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign hit      = pend_ff && (rd_data == key_ff);

   bdqs_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_key),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         back_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         issued_ff    <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         issued_ff    <= issued_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      issued_in     = issued_ff;
      pend_in       = 1'b0;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = back_ff;
      rd_en         = 1'b0;
      status        = ST_OK;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               case (req_op)
                  OP_PUT_BACK: begin
                     if (is_full) begin
                        status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_ff;
                        back_in  = slot_next(back_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_PUT_FRONT: begin
                     if (is_full) begin
                        status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = slot_prev(front_ff);
                        front_in = slot_prev(front_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_TAKE_BACK: begin
                     if (is_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        back_in  = slot_prev(back_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_TAKE_FRONT: begin
                     if (is_empty) begin
                        status = ST_EMPTY;
                     end else begin
                        front_in = slot_next(front_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     key_in    = req_key;
                     pos_in    = front_ff;
                     issued_in = '0;
                     found_in  = 1'b0;
                     state_in  = S_SCAN;
                  end
                  OP_CLEAR: begin
                     front_in = '0;
                     back_in  = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
               if (req_op != OP_SEARCH) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status;
                  rsp_occ_in    = count_in;
               end
            end
         end
         S_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (issued_ff != count_ff) begin
               rd_en     = 1'b1;
               pos_in    = slot_next(pos_ff);
               issued_in = issued_ff + 1'b1;
               pend_in   = 1'b1;
            end
            if (hit) begin
               found_in = 1'b1;
            end
            if (hit || (issued_ff == count_ff && !pend_ff)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = found_ff ? ST_OK : ST_NOT_FOUND;
               rsp_occ_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign occ_ext    = {{OCC_W{1'b0}}, rsp_occ_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - STAT_W - OCC_W){1'b0}},
                        occ_ext[OCC_W-1:0], rsp_status_ff};

   `BDQS_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY),
      "entry count above capacity")
   `BDQS_ASSERT_ALWAYS(a_empty_ring, (count_ff != '0) || (front_ff == back_ff),
      "empty queue with front and back apart")
   `BDQS_ASSERT_ALWAYS(a_scan_bound, (state_ff != S_SCAN) || (issued_ff <= count_ff),
      "search read past the stored entries")
   `BDQS_ASSERT_NEXT(a_search_keeps, state_ff != S_IDLE,
      $stable(count_ff) && $stable(front_ff) && $stable(back_ff),
      "queue changed during a search")

endmodule
